@@ hw/rtl/zefp_pkg.sv @@
// ----------------------------------------------------------------------------
// zefp_pkg
// shared types and constants of the zip extra-field parser
// ----------------------------------------------------------------------------
package zefp_pkg;

  localparam int CaptureDepth = 13;
  localparam int QueueDepth   = 2;
  localparam int CfgIndexW    = 1;
  localparam int CfgDataW     = 16;

  localparam logic [15:0] TsLength   = 16'd13;
  localparam logic [15:0] IdsLength  = 16'd11;
  localparam logic [7:0]  IdsVersion = 8'd1;
  localparam logic [7:0]  IdsSize    = 8'd4;

  localparam logic [15:0] TimestampTagReset = 16'h5455;
  localparam logic [15:0] UnixIdsTagReset   = 16'h7875;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_TIMESTAMP_TAG = 1'b0,
    CFG_UNIX_IDS_TAG  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  time_flags;
    logic [31:0] modify_time;
    logic [31:0] access_time;
    logic [31:0] create_time;
    logic [31:0] owner_id;
    logic [31:0] group_id;
  } out_word_t;

  // record boundary or end of area, handed from front to back
  typedef struct packed {
    logic                              finish;
    logic                              last;
    logic [15:0]                       tag;
    logic [15:0]                       length;
    logic [CaptureDepth-1:0][7:0]      capture;
  } rec_evt_t;

  typedef struct packed {
    logic     push;
    rec_evt_t evt;
  } evt_push_t;

  typedef struct packed {
    logic     valid;
    rec_evt_t evt;
  } evt_head_t;

endpackage

@@ hw/rtl/zefp_stream_if.sv @@
// ----------------------------------------------------------------------------
// zefp_stream_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface zefp_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

@@ hw/rtl/zefp_front.sv @@
// ----------------------------------------------------------------------------
// zefp_front
// byte tracker: walks record headers, captures payload, flags record and area ends
// ----------------------------------------------------------------------------
module zefp_front
  import zefp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  zefp_stream_if.sink            area,
  input  logic                   queue_full,
  output evt_push_t              push
);

  localparam int CapIdxW = $clog2(CaptureDepth);

  logic [1:0]                   header_count, header_count_next;
  logic                         in_payload, in_payload_next;
  logic [15:0]                  record_tag, record_tag_next;
  logic [15:0]                  record_length, record_length_next;
  logic [15:0]                  payload_count, payload_count_next;
  logic [CaptureDepth-1:0][7:0] capture, capture_next;
  logic [15:0]                  count_inc;
  logic                         finish;
  logic                         accept;
  logic [7:0]                   b;

  assign area.ready = !queue_full;
  assign accept     = area.valid && area.ready;
  assign b          = area.payload.data_byte;
  assign count_inc  = payload_count + 16'd1;

  always_comb begin
    header_count_next  = header_count;
    in_payload_next    = in_payload;
    record_tag_next    = record_tag;
    record_length_next = record_length;
    payload_count_next = payload_count;
    capture_next       = capture;
    finish             = 1'b0;
    if (!in_payload) begin
      unique case (header_count)
        2'd0: record_tag_next = {8'h00, b};
        2'd1: record_tag_next = {b, record_tag[7:0]};
        2'd2: record_length_next = {8'h00, b};
        default: record_length_next = {b, record_length[7:0]};
      endcase
      if (header_count == 2'd3) begin
        payload_count_next = '0;
        header_count_next  = '0;
        if (record_length_next == 16'd0) begin
          finish = 1'b1;
        end else begin
          in_payload_next = 1'b1;
        end
      end else begin
        header_count_next = header_count + 2'd1;
      end
    end else begin
      if (payload_count < 16'(CaptureDepth)) begin
        capture_next[payload_count[CapIdxW-1:0]] = b;
      end
      payload_count_next = count_inc;
      if (count_inc == record_length) begin
        finish             = 1'b1;
        in_payload_next    = 1'b0;
        payload_count_next = '0;
        header_count_next  = '0;
      end
    end
  end

  always_comb begin
    push.push        = accept && (finish || area.payload.last_byte);
    push.evt.finish  = finish;
    push.evt.last    = area.payload.last_byte;
    push.evt.tag     = record_tag_next;
    push.evt.length  = record_length_next;
    push.evt.capture = capture_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      in_payload    <= 1'b0;
      record_tag    <= '0;
      record_length <= '0;
      payload_count <= '0;
    end else if (accept) begin
      if (area.payload.last_byte) begin
        header_count  <= '0;
        in_payload    <= 1'b0;
        record_tag    <= '0;
        record_length <= '0;
        payload_count <= '0;
      end else begin
        header_count  <= header_count_next;
        in_payload    <= in_payload_next;
        record_tag    <= record_tag_next;
        record_length <= record_length_next;
        payload_count <= payload_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      capture <= capture_next;
    end
  end

endmodule

@@ hw/rtl/zefp_queue.sv @@
// ----------------------------------------------------------------------------
// zefp_queue
// short fifo of record events between the front and the back
// ----------------------------------------------------------------------------
module zefp_queue
  import zefp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  evt_push_t push,
  input  logic      pop,
  output evt_head_t head,
  output logic      full
);

  localparam int PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountW = $clog2(QueueDepth + 1);

  rec_evt_t            entries [QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CountW-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CountW'(QueueDepth));
  assign head.valid = (count != '0);
  assign head.evt   = entries[rd_ptr];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CountW'(1);
        2'b01:   count <= count - CountW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.evt;
    end
  end

endmodule

@@ hw/rtl/zefp_back.sv @@
// ----------------------------------------------------------------------------
// zefp_back
// record decoder: updates accumulated fields and emits them at area end
// ----------------------------------------------------------------------------
module zefp_back
  import zefp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] timestamp_tag,
  input  logic [15:0] unix_ids_tag,
  input  evt_head_t   head,
  output logic        pop,
  zefp_stream_if.source result
);

  out_word_t acc, acc_next;
  rec_evt_t  e;

  assign e   = head.evt;
  assign pop = head.valid && (!e.last || !result.valid || result.ready);

  always_comb begin
    acc_next = acc;
    if (e.finish) begin
      if (e.tag == timestamp_tag) begin
        if (e.length == TsLength) begin
          acc_next.time_flags = e.capture[0];
          if (e.capture[0][0]) begin
            acc_next.modify_time = {e.capture[4], e.capture[3], e.capture[2], e.capture[1]};
          end
          if (e.capture[0][1]) begin
            acc_next.access_time = {e.capture[8], e.capture[7], e.capture[6], e.capture[5]};
          end
          if (e.capture[0][2]) begin
            acc_next.create_time = {e.capture[12], e.capture[11], e.capture[10], e.capture[9]};
          end
        end
      end else if (e.tag == unix_ids_tag) begin
        if (e.length == IdsLength && e.capture[0] == IdsVersion &&
            e.capture[1] == IdsSize && e.capture[6] == IdsSize) begin
          acc_next.owner_id = {e.capture[5], e.capture[4], e.capture[3], e.capture[2]};
          acc_next.group_id = {e.capture[10], e.capture[9], e.capture[8], e.capture[7]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (pop && e.last) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (pop) begin
        if (e.last) begin
          acc <= '0;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && e.last) begin
      result.payload <= acc_next;
    end
  end

endmodule

@@ hw/rtl/zip_extra_field_parser.sv @@
// ----------------------------------------------------------------------------
// zip_extra_field_parser
// streaming tag/length/value parser for one zip extra-field area
// ----------------------------------------------------------------------------
// Takes one byte per clock and sustains that rate indefinitely while the
// result side keeps up. The front tracks record headers and captures payload
// bytes; each record end or area end goes into a two-entry event queue, and
// the back decodes timestamp and unix-id records from it. The area-end event
// enters the queue as the last byte is taken; the back pops it and registers
// the result word. If it is not taken, the queue absorbs more events before
// byte input stalls. Tag registers are written through the cfg port; the user
// must do so only while no area is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module zip_extra_field_parser
  import zefp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  zefp_stream_if.sink          area,
  zefp_stream_if.source        result,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic [15:0] timestamp_tag;
  logic [15:0] unix_ids_tag;
  evt_push_t   push;
  evt_head_t   head;
  logic        queue_full;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp_tag <= TimestampTagReset;
      unix_ids_tag  <= UnixIdsTagReset;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TIMESTAMP_TAG: timestamp_tag <= cfg_data[15:0];
        CFG_UNIX_IDS_TAG:  unix_ids_tag  <= cfg_data[15:0];
      endcase
    end
  end

  zefp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .area       (area),
    .queue_full (queue_full),
    .push       (push)
  );

  zefp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  zefp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timestamp_tag (timestamp_tag),
    .unix_ids_tag  (unix_ids_tag),
    .head          (head),
    .pop           (pop),
    .result        (result)
  );

  // every accepted last byte produces an event
  assert property (@(posedge clk) disable iff (rst)
    (area.valid && area.ready && area.payload.last_byte) |-> push.push)
    else $error("last byte produced no event");

  // no event pushed into a full queue
  assert property (@(posedge clk) disable iff (rst)
    push.push |-> !queue_full)
    else $error("event pushed into full queue");

  // a new result word only follows a popped area-end event
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(pop && head.evt.last))
    else $error("result without area end");

  // no result right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid after reset");

endmodule
